FILE: rtl/npo_pkg.sv
// Shared types, constants and helper functions of the palette-to-RGB565 overlay block.
package npo_pkg;

  localparam int SCREEN_SIZE = 128;
  localparam int CNT_W       = $clog2(SCREEN_SIZE);
  localparam int ORIGIN      = SCREEN_SIZE - 9;

  localparam int PAL_DEPTH   = 16;
  localparam int PAL_IDX_W   = $clog2(PAL_DEPTH);
  localparam int COLOR_W     = 16;
  localparam int POS_W       = 7;
  localparam int RATE_W      = 7;
  localparam int CFG_IDX_W   = 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int S_TDATA_W   = 40;
  localparam int M_TDATA_W   = 32;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_RATE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_VALUE = 1'd1;

  // Item kinds on the input tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  localparam logic [RATE_W-1:0]  RATE_MAX    = 7'd99;
  localparam logic [RATE_W-1:0]  RATE_GOOD   = 7'd28;
  localparam logic [COLOR_W-1:0] COLOR_RED   = 16'h00F8;
  localparam logic [COLOR_W-1:0] COLOR_GREEN = 16'hE007;

  // 3x5 digit font, three 5-bit columns per digit, bit r lights glyph row r
  localparam logic [4:0] FONT [30] = '{
    5'h1F, 5'h11, 5'h1F,  5'h00, 5'h1F, 5'h00,  5'h1D, 5'h15, 5'h17,
    5'h15, 5'h15, 5'h1F,  5'h07, 5'h04, 5'h1F,  5'h17, 5'h15, 5'h1D,
    5'h1F, 5'h15, 5'h1D,  5'h01, 5'h01, 5'h1F,  5'h1F, 5'h15, 5'h1F,
    5'h17, 5'h15, 5'h1F
  };

  typedef struct packed {
    logic [COLOR_W-1:0] c_lo;
    logic [COLOR_W-1:0] c_hi;
  } pair_t;

  typedef struct packed {
    logic              show;
    logic [RATE_W-1:0] rate;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic               pair_last;
    logic               frame_last;
  } pix_t;

  function automatic logic [4:0] font_col(logic [3:0] digit, logic [1:0] k);
    logic [4:0] idx;
    idx = 5'(digit * 3) + 5'(k);
    if (digit < 4'd10 && k < 2'd3) begin
      return FONT[idx];
    end
    return 5'h00;
  endfunction

  // Tens digit of a value up to 99 by reciprocal multiply (x*205 >> 11)
  function automatic logic [3:0] tens_of(logic [RATE_W-1:0] num);
    logic [14:0] prod;
    prod = 15'(num) * 15'd205;
    return prod[14:11];
  endfunction

endpackage

FILE: rtl/npo_front.sv
// Front end: accepts words, writes palette entries, looks up both pixel colours of a frame byte.
module npo_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [npo_pkg::PAL_IDX_W-1:0]  pal_index_i,
  input  logic [7:0]                     red_i,
  input  logic [7:0]                     green_i,
  input  logic [7:0]                     blue_i,
  input  logic [7:0]                     pixel_pair_i,
  output logic                           push_o,
  output npo_pkg::pair_t                 push_data_o,
  input  logic                           full_i
);
  import npo_pkg::*;

  logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
  logic               stage_v_q, stage_v_d;
  pair_t              stage_q;
  logic               accept, load_we, pix_acc;
  logic [COLOR_W-1:0] c565, swapped;

  assign in_ready_o = !stage_v_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign load_we    = accept && (req_type_i == REQ_LOAD);
  assign pix_acc    = accept && (req_type_i == REQ_PIXEL);
  assign push_o     = stage_v_q && !full_i;
  assign push_data_o = stage_q;

  assign c565    = {red_i[7:3], green_i[7:2], blue_i[7:3]};
  assign swapped = {c565[7:0], c565[15:8]};

  always_comb begin
    stage_v_d = stage_v_q;
    if (pix_acc) begin
      stage_v_d = 1'b1;
    end else if (push_o) begin
      stage_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else begin
      stage_v_q <= stage_v_d;
    end
  end

  // Palette: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      pal_mem[pal_index_i] <= swapped;
    end
    if (pix_acc) begin
      stage_q.c_lo <= pal_mem[pixel_pair_i[3:0]];
      stage_q.c_hi <= pal_mem[pixel_pair_i[7:4]];
    end
  end

endmodule

FILE: rtl/npo_fifo.sv
// Short queue of looked-up colour pairs between front and back end.
module npo_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  npo_pkg::pair_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output npo_pkg::pair_t pop_data_o
);
  import npo_pkg::*;

  pair_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/npo_back.sv
// Back end: splits colour pairs into pixels, tracks raster position, draws the rate overlay.
module npo_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  npo_pkg::cfg_t  cfg_i,
  input  logic           empty_i,
  input  npo_pkg::pair_t pop_data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output npo_pkg::pix_t  out_o
);
  import npo_pkg::*;

  logic               phase_q, phase_d;
  logic [COLOR_W-1:0] hi_q;
  logic               out_v_q, out_v_d;
  pix_t               out_q;
  logic [CNT_W-1:0]   col_q, col_d, row_q, row_d;
  logic               load_out, emit_lo, emit_hi, emit;
  logic [COLOR_W-1:0] pal_color, color;
  logic [RATE_W-1:0]  num;
  logic [3:0]         tens, units;
  logic [CNT_W-1:0]   dx;
  logic [2:0]         bitsel;
  logic [4:0]         glyph;
  logic               in_zone, hit, at_col_end, at_row_end;

  assign load_out = !out_v_q || out_ready_i;
  assign emit_hi  = load_out && phase_q;
  assign emit_lo  = load_out && !phase_q && !empty_i;
  assign emit     = emit_hi || emit_lo;
  assign pop_o    = emit_lo;

  assign pal_color = emit_hi ? hi_q : pop_data_i.c_lo;

  // Overlay
  assign num     = (cfg_i.rate > RATE_MAX) ? RATE_MAX : cfg_i.rate;
  assign tens    = tens_of(num);
  assign units   = 4'(num - RATE_W'(tens) * RATE_W'(10));
  assign dx      = col_q - CNT_W'(ORIGIN);
  assign bitsel  = 3'(row_q - CNT_W'(1));
  assign in_zone = cfg_i.show && (col_q >= CNT_W'(ORIGIN))
                   && (row_q >= CNT_W'(1)) && (row_q <= CNT_W'(5));

  always_comb begin
    glyph = 5'h00;
    if (dx < CNT_W'(3)) begin
      glyph = (tens != 4'd0) ? font_col(tens, 2'(dx)) : 5'h00;
    end else if (dx >= CNT_W'(4) && dx < CNT_W'(7)) begin
      glyph = font_col(units, 2'(dx - CNT_W'(4)));
    end
  end

  assign hit   = in_zone && glyph[bitsel];
  assign color = hit ? ((num < RATE_GOOD) ? COLOR_RED : COLOR_GREEN) : pal_color;

  assign at_col_end = (col_q == CNT_W'(SCREEN_SIZE - 1));
  assign at_row_end = (row_q == CNT_W'(SCREEN_SIZE - 1));

  always_comb begin
    phase_d = phase_q;
    out_v_d = out_v_q;
    col_d   = col_q;
    row_d   = row_q;
    if (out_ready_i) begin
      out_v_d = 1'b0;
    end
    if (emit) begin
      out_v_d = 1'b1;
      phase_d = emit_lo;
      col_d   = at_col_end ? '0 : col_q + 1'b1;
      if (at_col_end) begin
        row_d = at_row_end ? '0 : row_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      out_v_q <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      phase_q <= phase_d;
      out_v_q <= out_v_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_lo) begin
      hi_q <= pop_data_i.c_hi;
    end
    if (emit) begin
      out_q.color      <= color;
      out_q.col        <= POS_W'(col_q);
      out_q.row        <= POS_W'(row_q);
      out_q.pair_last  <= emit_hi;
      out_q.frame_last <= at_col_end && at_row_end;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

FILE: rtl/nibble_palette_to_rgb565_overlay_top.sv
// Top level of the 4bpp palette to byte-swapped RGB565 converter with rate overlay.
// Path: a frame byte accepted at the input passes the palette read stage, the queue and the
//   output register before its first pixel shows on the output; the second pixel follows.
// Throughput: one pixel word per cycle at the output while it is not stalled, so a frame byte
//   gives two pixel words; palette loads produce nothing.
// Reset (rst_ni, async, active low) clears counters, queue, configuration and valid registers
//   and the output valid; palette entries hold garbage until loaded.
module nibble_palette_to_rgb565_overlay_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [npo_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [npo_pkg::RATE_W-1:0]      cfg_data_i,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [3:0] pal_index, [11:4] red, [19:12] green, [27:20] blue, [35:28] pixel_pair, rest 0
  input  logic [npo_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] req_type
  input  logic                            s_axis_tuser,
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [15:0] pixel_color, [22:16] pixel_col, [29:23] pixel_row, rest 0
  output logic [npo_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [0] pair_last
  output logic                            m_axis_tuser,
  // frame_last
  output logic                            m_axis_tlast
);
  import npo_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  push, full, pop, empty;
  pair_t push_data, pop_data;
  pix_t  pix;

  // Configuration registers; the user must write them only while the datapath is idle, the block does not enforce it
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHOW_RATE:  cfg_d.show = cfg_data_i[0];
        CFG_RATE_VALUE: cfg_d.rate = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: palette writes and colour lookup of both nibbles
  npo_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .req_type_i   (s_axis_tuser),
    .pal_index_i  (s_axis_tdata[3:0]),
    .red_i        (s_axis_tdata[11:4]),
    .green_i      (s_axis_tdata[19:12]),
    .blue_i       (s_axis_tdata[27:20]),
    .pixel_pair_i (s_axis_tdata[35:28]),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  npo_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  // Back: one pixel per cycle while pairs are queued and the output is not stalled, raster counters and overlay
  npo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (pix)
  );

  assign m_axis_tdata = {2'b00, pix.row, pix.col, pix.color};
  assign m_axis_tuser = pix.pair_last;
  assign m_axis_tlast = pix.frame_last;

endmodule

FILE: rtl/npo_checker.sv
// Port-level checks of the converter, bound to the top level.
module npo_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [npo_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);
  import npo_pkg::*;

  // Stalled output word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");

  // Second pixel of a byte follows the first without a gap
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tuser |=> m_axis_tvalid && m_axis_tuser)
    else $error("second pixel of pair missing");

  // Pair position matches column parity
  a_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == m_axis_tdata[16]))
    else $error("pair_last does not match column parity");

  // Frame end only at the bottom-right pixel
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tuser && (m_axis_tdata[22:16] == POS_W'(SCREEN_SIZE - 1))
      && (m_axis_tdata[29:23] == POS_W'(SCREEN_SIZE - 1)))
    else $error("frame_last at wrong position");

endmodule

bind nibble_palette_to_rgb565_overlay_top npo_checker u_npo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: verif/tb.sv
// Testbench of the 4bpp palette to byte-swapped RGB565 converter with rate overlay.
module tb;
  import npo_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned STALL_CYCLES  = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned END_WAIT      = 20;
  localparam int unsigned REPORT_MAX    = 10;

  localparam int unsigned RATE_CAP  = 99;
  localparam int unsigned RATE_OK   = 28;
  localparam bit [15:0]   DIGIT_RED = 16'h00F8;
  localparam bit [15:0]   DIGIT_GRN = 16'hE007;
  localparam int unsigned LAST_POS  = SCREEN_SIZE - 1;
  localparam int unsigned DIGIT_X0  = SCREEN_SIZE - 9;

  typedef struct packed {
    bit [15:0] color;
    bit [6:0]  col;
    bit [6:0]  row;
    bit        pair_last;
    bit        frame_last;
  } pixel_t;

  // Tracks palette, raster position and overlay setting; holds the pixels still owed
  class pixel_scoreboard;
    bit [15:0]   palette [16];
    int unsigned col = 0;
    int unsigned row = 0;
    bit          show = 1'b0;
    bit [6:0]    rate = '0;
    pixel_t      owed_q [$];
    int unsigned loads = 0, bytes = 0, checked = 0, wraps = 0, lit = 0, errors = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] val);
      if (idx == CFG_SHOW_RATE) show = val[0];
      else if (idx == CFG_RATE_VALUE) rate = val;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Font columns of a digit, {col2, col1, col0}; bit r of a column lights glyph row r
    function bit [14:0] glyph(int unsigned d);
      case (d)
        0: return {5'h1F, 5'h11, 5'h1F};
        1: return {5'h00, 5'h1F, 5'h00};
        2: return {5'h17, 5'h15, 5'h1D};
        3: return {5'h1F, 5'h15, 5'h15};
        4: return {5'h1F, 5'h04, 5'h07};
        5: return {5'h1D, 5'h15, 5'h17};
        6: return {5'h1D, 5'h15, 5'h1F};
        7: return {5'h1F, 5'h01, 5'h01};
        8: return {5'h1F, 5'h15, 5'h1F};
        9: return {5'h1F, 5'h15, 5'h17};
        default: return '0;
      endcase
    endfunction

    function int unsigned shown_rate();
      return (rate > RATE_CAP) ? RATE_CAP : int'(rate);
    endfunction

    function bit digit_lit(int unsigned c, int unsigned r);
      int unsigned num, dx;
      bit [14:0] g;
      if (!show || r < 1 || r > 5 || c < DIGIT_X0) return 1'b0;
      num = shown_rate();
      dx  = c - DIGIT_X0;
      if (dx < 3) begin
        // tens digit of zero stays blank
        if (num / 10 == 0) return 1'b0;
        g = glyph(num / 10);
        return g[dx * 5 + r - 1];
      end
      if (dx >= 4 && dx < 7) begin
        g = glyph(num % 10);
        return g[(dx - 4) * 5 + r - 1];
      end
      return 1'b0;
    endfunction

    function void push_pixel(bit [3:0] nib, bit second);
      pixel_t p;
      p.color = palette[nib];
      if (digit_lit(col, row)) begin
        p.color = (shown_rate() < RATE_OK) ? DIGIT_RED : DIGIT_GRN;
        lit++;
      end
      p.col        = col[6:0];
      p.row        = row[6:0];
      p.pair_last  = second;
      p.frame_last = (col == LAST_POS) && (row == LAST_POS);
      owed_q.push_back(p);
      if (col == LAST_POS) begin
        col = 0;
        if (row == LAST_POS) begin
          row = 0;
          wraps++;
        end else begin
          row++;
        end
      end else begin
        col++;
      end
    endfunction

    function void note_word(logic kind, logic [S_TDATA_W-1:0] data);
      bit [15:0] c565;
      if (kind == REQ_LOAD) begin
        c565 = {data[11:7], data[19:14], data[27:23]};
        palette[data[3:0]] = {c565[7:0], c565[15:8]};
        loads++;
      end else begin
        push_pixel(data[31:28], 1'b0);
        push_pixel(data[35:32], 1'b1);
        bytes++;
      end
    endfunction

    function void check_word(logic [M_TDATA_W-1:0] data, logic user, logic last);
      pixel_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected pixel word: color %h col %0d row %0d pair %b last %b",
                   data[15:0], data[22:16], data[29:23], user, last);
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (data[15:0] !== want.color || data[22:16] !== want.col ||
          data[29:23] !== want.row || user !== want.pair_last ||
          last !== want.frame_last) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("pixel mismatch: expected color %h col %0d row %0d pair %b last %b, %s",
                   want.color, want.col, want.row, want.pair_last, want.frame_last,
                   $sformatf("got color %h col %0d row %0d pair %b last %b",
                             data[15:0], data[22:16], data[29:23], user, last));
      end
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [RATE_W-1:0]      cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  pixel_scoreboard board;
  int unsigned     send_gap_pct = 0;
  int unsigned     recv_gap_pct = 0;
  int unsigned     stall_asks   = 0;   // bumped by the stimulus to ask for a long hold-off
  int unsigned     stall_seen   = 0;
  int unsigned     hold_left    = 0;
  int unsigned     cycle_count  = 0;
  int unsigned     cfg_writes   = 0;
  int unsigned     listed_step  = 0;

  nibble_palette_to_rgb565_overlay_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still owed", cycle_count,
               board.pending());
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: checks accepted pixel words, random back-pressure, long hold-off on request
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      board.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    if (stall_seen != stall_asks) begin
      stall_seen = stall_asks;
      hold_left  = STALL_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // tvalid is only raised or lowered once per edge; it stays high across back-to-back words
  task automatic send_word(input logic kind, input logic [S_TDATA_W-1:0] data);
    if ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_word(kind, data);
  endtask

  // Unused fields of a word carry random bits; the top four bits stay zero
  task automatic send_load(input bit [3:0] idx, input bit [7:0] r, input bit [7:0] g,
                           input bit [7:0] b);
    send_word(REQ_LOAD, {4'h0, 8'($urandom), b, g, r, idx});
  endtask

  task automatic send_pixel(input bit [7:0] pair);
    send_word(REQ_PIXEL, {4'h0, pair, 24'($urandom), 4'($urandom)});
  endtask

  // Wait for every owed pixel, then let trailing palette loads retire
  task automatic settle();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input bit show, input bit [6:0] rate);
    logic [RATE_W-1:0] show_word;
    show_word  = {6'($urandom), show};   // upper bits are don't-care for the enable
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SHOW_RATE;
    cfg_data_i <= show_word;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_RATE_VALUE;
    cfg_data_i <= rate;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    board.write_reg(CFG_SHOW_RATE, show_word);
    board.write_reg(CFG_RATE_VALUE, rate);
    cfg_writes++;
  endtask

  // {show, rate}: every digit in both places, red/green threshold, clamp, blank tens
  function automatic bit [7:0] listed_setting(int unsigned k);
    case (k)
      0:  return {1'b1, 7'd0};
      1:  return {1'b1, 7'd7};
      2:  return {1'b1, 7'd27};
      3:  return {1'b1, 7'd28};
      4:  return {1'b1, 7'd99};
      5:  return {1'b1, 7'd100};
      6:  return {1'b1, 7'd127};
      7:  return {1'b0, 7'd55};
      8:  return {1'b1, 7'd19};
      9:  return {1'b1, 7'd36};
      10: return {1'b1, 7'd45};
      11: return {1'b1, 7'd52};
      12: return {1'b1, 7'd63};
      13: return {1'b1, 7'd74};
      14: return {1'b1, 7'd81};
      default: return 8'($urandom);
    endcase
  endfunction

  // Segments of random words with an idle config change between them. Near the top rows,
  // where the digits sit, segments are short so many settings get drawn.
  task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                           input int unsigned quota, input bit into_next_frame,
                           input bit with_stall);
    int unsigned sent, seg_len;
    bit [7:0]    setting;
    sent         = 0;
    send_gap_pct = s_pct;
    recv_gap_pct = r_pct;
    while (into_next_frame ? !(board.wraps != 0 && board.row >= 7) : sent < quota) begin
      settle();
      if (board.row <= 5) begin
        setting = listed_setting(listed_step);
        listed_step++;
      end else begin
        setting = 8'($urandom);
      end
      write_config(setting[7], setting[6:0]);
      if (with_stall && sent == 0) stall_asks++;
      seg_len = (board.row <= 5) ? $urandom_range(40, 8) : $urandom_range(160, 40);
      repeat (seg_len) begin
        if ($urandom_range(99) < 15)
          send_load(4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else
          send_pixel(8'($urandom));
        sent++;
      end
      s_axis_tvalid <= 1'b0;
    end
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fill the whole palette first, color extremes and dropped low bits
    for (int i = 0; i < 16; i++) begin
      case (i)
        0:       send_load(4'(i), 8'h00, 8'h00, 8'h00);
        1:       send_load(4'(i), 8'hFF, 8'hFF, 8'hFF);
        2:       send_load(4'(i), 8'hFF, 8'h00, 8'h00);
        3:       send_load(4'(i), 8'h00, 8'hFF, 8'h00);
        4:       send_load(4'(i), 8'h00, 8'h00, 8'hFF);
        5:       send_load(4'(i), 8'h07, 8'h03, 8'h07);
        6:       send_load(4'(i), 8'h08, 8'h04, 8'h08);
        default: send_load(4'(i), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
    // every nibble value on one side or the other of a byte, plus the byte extremes
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h10);
    send_pixel(8'h32);
    send_pixel(8'h54);
    send_pixel(8'h76);
    send_pixel(8'h98);
    send_pixel(8'hBA);
    send_pixel(8'hEF);
    send_pixel(8'hCD);
    s_axis_tvalid <= 1'b0;

    run_phase(24, 82, 650, 1'b0, 1'b0);
    run_phase(82, 24, 650, 1'b0, 1'b0);
    // no idling, with one long receiver hold-off while the sender keeps offering
    run_phase(0, 0, 650, 1'b0, 1'b1);

    while (board.pending() != 0) @(posedge clk_i);
    repeat (END_WAIT) @(posedge clk_i);

    $display("sent %0d words: %0d palette loads, %0d frame bytes; %0d pixels compared",
             board.loads + board.bytes, board.loads, board.bytes, board.checked);
    $display("%0d overlay settings, %0d digit pixels drawn, %0d frame wrap(s), %0d errors",
             cfg_writes, board.lit, board.wraps, board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
